>>> src/rsqr_pkg.sv
package rsqr_pkg;

  localparam int ROB_DEPTH  = 128;
  localparam int SQ_DEPTH   = 32;
  localparam int TICK_WIDTH = 32;
  localparam int LAT_W      = 10;
  localparam int BW_W       = 4;
  localparam logic [BW_W-1:0] BW_RESET = 4'd8;

  localparam int ROB_AW = $clog2(ROB_DEPTH);
  localparam int ROB_CW = $clog2(ROB_DEPTH + 1);
  localparam int ROB_SW = ROB_CW + 1;
  localparam int SQ_AW  = $clog2(SQ_DEPTH);
  localparam int SQ_CW  = $clog2(SQ_DEPTH + 1);
  localparam int SQ_SW  = SQ_CW + 1;

  localparam logic OP_FETCH  = 1'b0;
  localparam logic OP_RETIRE = 1'b1;

  typedef struct packed {
    logic [TICK_WIDTH-1:0] done;
    logic [LAT_W-1:0]      lat;
    logic                  st;
  } rob_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_RD,
    S_SQ_CHK,
    S_ROB_RD,
    S_ROB_CHK,
    S_HEAD,
    S_DONE
  } state_t;

  function automatic logic [ROB_AW-1:0] rob_add(input logic [ROB_AW-1:0] base,
                                                 input logic [ROB_CW-1:0] offs);
    logic [ROB_SW-1:0] s;
    s = ROB_SW'(base) + ROB_SW'(offs);
    if (s >= ROB_SW'(ROB_DEPTH)) s = s - ROB_SW'(ROB_DEPTH);
    return s[ROB_AW-1:0];
  endfunction

  function automatic logic [SQ_AW-1:0] sq_add(input logic [SQ_AW-1:0] base,
                                               input logic [SQ_CW-1:0] offs);
    logic [SQ_SW-1:0] s;
    s = SQ_SW'(base) + SQ_SW'(offs);
    if (s >= SQ_SW'(SQ_DEPTH)) s = s - SQ_SW'(SQ_DEPTH);
    return s[SQ_AW-1:0];
  endfunction

endpackage

>>> src/rob_store_queue_retire.sv
// Fetch: the accepted word passes S_HEAD and S_DONE before out_valid is registered.
// Retire: the walk frees reached store queue entries, then retires buffer
//   entries up to the bandwidth; one shared compare/add unit and one read port on
//   each queue memory pace the walk.
// One word in flight; in_stall is high until the result is registered.
// Reset clears pointers, counts, out_valid and sets the bandwidth register to 8.
module rob_store_queue_retire
  import rsqr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [BW_W-1:0]       cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [TICK_WIDTH-1:0] tick,
  input  logic [TICK_WIDTH-1:0] complete_tick,
  input  logic [LAT_W-1:0]      store_latency,
  input  logic                  enters_store_queue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  accepted,
  output logic [BW_W-1:0]       rob_drained,
  output logic [SQ_CW-1:0]      sq_drained,
  output logic [ROB_CW-1:0]     rob_occupancy,
  output logic [SQ_CW-1:0]      sq_occupancy,
  output logic [TICK_WIDTH-1:0] head_complete_tick,
  output logic [TICK_WIDTH-1:0] last_store_tick
);

  state_t                state, state_next;
  logic [ROB_AW-1:0]     rob_head;
  logic [ROB_CW-1:0]     rob_count;
  logic [SQ_AW-1:0]      sq_head;
  logic [SQ_CW-1:0]      sq_count;
  logic [BW_W-1:0]       bandwidth;
  logic [TICK_WIDTH-1:0] cur_tick;
  logic [BW_W-1:0]       rob_ret;
  logic [SQ_CW-1:0]      sq_ret;
  logic                  fetch_ok;
  logic [TICK_WIDTH-1:0] last_tick;

  logic                  in_acc;
  logic                  rob_we;
  rob_entry_t            rob_wdata, rob_rdata;
  logic [$bits(rob_entry_t)-1:0] rob_rraw;
  logic [TICK_WIDTH-1:0] sq_rdata;
  logic                  sq_full;

  logic                  sq_pop, rob_pop, sq_push, load_out;
  logic [TICK_WIDTH-1:0] alu_a;
  logic                  alu_le;
  logic [TICK_WIDTH-1:0] alu_sum;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign rob_we    = in_acc && (opcode == OP_FETCH) && (rob_count != ROB_CW'(ROB_DEPTH));
  assign sq_full   = (sq_count == SQ_CW'(SQ_DEPTH));
  assign rob_rdata = rob_entry_t'(rob_rraw);

  always_comb begin
    rob_wdata.done = complete_tick;
    rob_wdata.lat  = store_latency;
    rob_wdata.st   = enters_store_queue;
  end

  rsqr_ram #(
    .WIDTH($bits(rob_entry_t)),
    .DEPTH(ROB_DEPTH)
  ) u_rob_ram (
    .clk  (clk),
    .we   (rob_we),
    .waddr(rob_add(rob_head, rob_count)),
    .wdata(rob_wdata),
    .raddr(rob_head),
    .rdata(rob_rraw)
  );

  rsqr_ram #(
    .WIDTH(TICK_WIDTH),
    .DEPTH(SQ_DEPTH)
  ) u_sq_ram (
    .clk  (clk),
    .we   (sq_push),
    .waddr(sq_add(sq_head, sq_count)),
    .wdata(alu_sum),
    .raddr(sq_head),
    .rdata(sq_rdata)
  );

  rsqr_alu u_alu (
    .entry_tick(alu_a),
    .cur_tick  (cur_tick),
    .latency   (rob_rdata.lat),
    .reached   (alu_le),
    .store_tick(alu_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_pop     = 1'b0;
    rob_pop    = 1'b0;
    sq_push    = 1'b0;
    load_out   = 1'b0;
    alu_a      = sq_rdata;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (opcode == OP_RETIRE) ? S_SQ_RD : S_HEAD;
        end
      end
      S_SQ_RD: begin
        state_next = (sq_count == '0) ? S_ROB_RD : S_SQ_CHK;
      end
      S_SQ_CHK: begin
        if (alu_le) begin
          sq_pop     = 1'b1;
          state_next = S_SQ_RD;
        end else begin
          state_next = S_ROB_RD;
        end
      end
      S_ROB_RD: begin
        state_next = ((rob_count == '0) || (rob_ret >= bandwidth)) ? S_HEAD : S_ROB_CHK;
      end
      S_ROB_CHK: begin
        alu_a = rob_rdata.done;
        if (alu_le && !(rob_rdata.st && sq_full)) begin
          rob_pop    = 1'b1;
          sq_push    = rob_rdata.st;
          state_next = S_ROB_RD;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid && out_stall)) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rob_head  <= '0;
      rob_count <= '0;
      sq_head   <= '0;
      sq_count  <= '0;
      bandwidth <= BW_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bandwidth <= cfg_wr_data;
      end
      if (rob_we) begin
        rob_count <= rob_count + ROB_CW'(1);
      end else if (rob_pop) begin
        rob_count <= rob_count - ROB_CW'(1);
        rob_head  <= rob_add(rob_head, ROB_CW'(1));
      end
      if (sq_pop) begin
        sq_count <= sq_count - SQ_CW'(1);
        sq_head  <= sq_add(sq_head, SQ_CW'(1));
      end else if (sq_push) begin
        sq_count <= sq_count + SQ_CW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_tick <= tick;
      fetch_ok <= rob_we;
    end
    if (in_acc) begin
      rob_ret <= '0;
    end else if (rob_pop) begin
      rob_ret <= rob_ret + BW_W'(1);
    end
    if (in_acc) begin
      sq_ret <= '0;
    end else if (sq_pop) begin
      sq_ret <= sq_ret + SQ_CW'(1);
    end
    if (sq_push) begin
      last_tick <= alu_sum;
    end
    if (load_out) begin
      accepted           <= fetch_ok;
      rob_drained        <= rob_ret;
      sq_drained         <= sq_ret;
      rob_occupancy      <= rob_count;
      sq_occupancy       <= sq_count;
      head_complete_tick <= (rob_count != '0) ? rob_rdata.done : '0;
      last_store_tick    <= (sq_count != '0) ? last_tick : '0;
    end
  end

  a_rob_bound: assert property (@(posedge clk) disable iff (rst)
    rob_count <= ROB_CW'(ROB_DEPTH))
    else $error("reorder buffer count beyond depth");

  a_sq_bound: assert property (@(posedge clk) disable iff (rst)
    sq_count <= SQ_CW'(SQ_DEPTH))
    else $error("store queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    sq_push |-> !sq_full)
    else $error("store queue push while full");

  a_rob_stable: assert property (@(posedge clk) disable iff (rst)
    (!rob_we && !rob_pop) |=> (rob_count == $past(rob_count)))
    else $error("reorder buffer count moved without push or pop");

endmodule

>>> src/rsqr_ram.sv
module rsqr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rsqr_alu.sv
module rsqr_alu
  import rsqr_pkg::*;
(
  input  logic [TICK_WIDTH-1:0] entry_tick,
  input  logic [TICK_WIDTH-1:0] cur_tick,
  input  logic [LAT_W-1:0]      latency,
  output logic                  reached,
  output logic [TICK_WIDTH-1:0] store_tick
);

  assign reached    = (entry_tick <= cur_tick);
  assign store_tick = TICK_WIDTH'(latency) + cur_tick;

endmodule
